// ===== hw/rtl/spiv_pkg.sv =====
// Shared types and constants for the pixel index sorter.
`default_nettype none

package spiv_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 16384;
  localparam int unsigned VALUE_BITS_DEF = 8;
  localparam int unsigned PIX_VALUE_W    = 8;
  localparam int unsigned PIX_INDEX_W    = 14;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_PREFIX,
    ST_SC_PIX,
    ST_SC_CUR,
    ST_SC_WR,
    ST_FETCH_RD,
    ST_FETCH_WR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [PIX_INDEX_W-1:0] pixel_index;
    logic                   last_index;
    status_e                status;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spiv_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module spiv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/spiv_ctrl.sv =====
// Sequencer: bin clearing, histogram update, prefix sum, scatter and fetch.
`default_nettype none

module spiv_ctrl
  import spiv_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  localparam int unsigned IDX_W     = $clog2(MAX_PIXELS),
  localparam int unsigned CNT_W     = $clog2(MAX_PIXELS + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_accept_i,
  input  wire opcode_e               opcode_i,
  input  wire logic [VALUE_BITS-1:0] value_i,
  input  wire logic                  first_i,
  output logic                       ready_o,
  output logic                       res_valid_o,
  output res_t                       res_o,
  input  wire logic                  res_take_i,
  output logic                       bin_we_o,
  output logic [VALUE_BITS-1:0]      bin_addr_o,
  output logic [CNT_W-1:0]           bin_wdata_o,
  input  wire logic [CNT_W-1:0]      bin_rdata_i,
  output logic                       cur_we_o,
  output logic [VALUE_BITS-1:0]      cur_addr_o,
  output logic [CNT_W-1:0]           cur_wdata_o,
  input  wire logic [CNT_W-1:0]      cur_rdata_i,
  output logic                       pix_we_o,
  output logic [IDX_W-1:0]           pix_addr_o,
  output logic [VALUE_BITS-1:0]      pix_wdata_o,
  input  wire logic [VALUE_BITS-1:0] pix_rdata_i,
  output logic                       ord_we_o,
  output logic [IDX_W-1:0]           ord_addr_o,
  output logic [IDX_W-1:0]           ord_wdata_o,
  input  wire logic [IDX_W-1:0]      ord_rdata_i
);

  state_e                state_q, state_d;
  logic [VALUE_BITS-1:0] clr_q, clr_d;
  logic                  clr_load_q, clr_load_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      rdpos_q, rdpos_d;
  logic                  sorted_q, sorted_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [VALUE_BITS:0]   pf_addr_q, pf_addr_d;
  logic                  pf_vld_q, pf_vld_d;
  logic [VALUE_BITS-1:0] pf_wa_q, pf_wa_d;
  logic [CNT_W-1:0]      run_q, run_d;
  logic [CNT_W-1:0]      sc_i_q, sc_i_d;
  logic [VALUE_BITS-1:0] sc_val_q, sc_val_d;
  res_t                  res_q, res_d;
  logic [CNT_W-1:0]      sc_next;
  logic [CNT_W-1:0]      rd_next;
  logic                  full;

  assign sc_next = sc_i_q + CNT_W'(1);
  assign rd_next = rdpos_q + CNT_W'(1);
  assign full    = (count_q == CNT_W'(MAX_PIXELS));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) begin
          state_d = clr_load_q ? ST_LOAD_RD : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept_i) begin
          if (opcode_i == OP_LOAD) begin
            priority if (first_i) state_d = ST_CLEAR;
            else if (full)        state_d = ST_RESP;
            else                  state_d = ST_LOAD_RD;
          end else begin
            state_d = sorted_q ? ST_FETCH_RD : ST_PREFIX;
          end
        end
      end
      ST_LOAD_RD: state_d = ST_LOAD_WR;
      ST_LOAD_WR: state_d = ST_RESP;
      ST_PREFIX: begin
        if (pf_addr_q[VALUE_BITS] && pf_vld_q) begin
          state_d = (count_q == '0) ? ST_FETCH_RD : ST_SC_PIX;
        end
      end
      ST_SC_PIX: state_d = ST_SC_CUR;
      ST_SC_CUR: state_d = ST_SC_WR;
      ST_SC_WR:  state_d = (sc_next == count_q) ? ST_FETCH_RD : ST_SC_PIX;
      ST_FETCH_RD: state_d = (rdpos_q >= count_q) ? ST_RESP : ST_FETCH_WR;
      ST_FETCH_WR: state_d = ST_RESP;
      ST_RESP: begin
        if (res_take_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_d       = clr_q;
    clr_load_d  = clr_load_q;
    count_d     = count_q;
    rdpos_d     = rdpos_q;
    sorted_d    = sorted_q;
    value_d     = value_q;
    pf_addr_d   = pf_addr_q;
    pf_vld_d    = pf_vld_q;
    pf_wa_d     = pf_wa_q;
    run_d       = run_q;
    sc_i_d      = sc_i_q;
    sc_val_d    = sc_val_q;
    res_d       = res_q;
    ready_o     = 1'b0;
    res_valid_o = 1'b0;
    bin_we_o    = 1'b0;
    bin_addr_o  = '0;
    bin_wdata_o = '0;
    cur_we_o    = 1'b0;
    cur_addr_o  = '0;
    cur_wdata_o = '0;
    pix_we_o    = 1'b0;
    pix_addr_o  = '0;
    pix_wdata_o = '0;
    ord_we_o    = 1'b0;
    ord_addr_o  = '0;
    ord_wdata_o = '0;
    unique case (state_q)
      ST_CLEAR: begin
        bin_we_o   = 1'b1;
        bin_addr_o = clr_q;
        clr_d      = clr_q + VALUE_BITS'(1);
      end
      ST_IDLE: begin
        ready_o = 1'b1;
        if (in_accept_i) begin
          value_d = value_i;
          res_d   = '{pixel_index: '0, last_index: 1'b0, status: STAT_OK};
          if (opcode_i == OP_LOAD) begin
            sorted_d = 1'b0;
            rdpos_d  = '0;
            if (first_i) begin
              count_d    = '0;
              clr_load_d = 1'b1;
            end else if (full) begin
              res_d.status = STAT_FULL;
            end
          end else if (!sorted_q) begin
            pf_addr_d = '0;
            pf_vld_d  = 1'b0;
            run_d     = '0;
          end
        end
      end
      ST_LOAD_RD: begin
        bin_addr_o  = value_q;
        pix_we_o    = 1'b1;
        pix_addr_o  = count_q[IDX_W-1:0];
        pix_wdata_o = value_q;
      end
      ST_LOAD_WR: begin
        bin_we_o    = 1'b1;
        bin_addr_o  = value_q;
        bin_wdata_o = bin_rdata_i + CNT_W'(1);
        count_d     = count_q + CNT_W'(1);
      end
      ST_PREFIX: begin
        if (!pf_addr_q[VALUE_BITS]) begin
          bin_addr_o = pf_addr_q[VALUE_BITS-1:0];
          pf_addr_d  = pf_addr_q + (VALUE_BITS + 1)'(1);
          pf_wa_d    = pf_addr_q[VALUE_BITS-1:0];
          pf_vld_d   = 1'b1;
        end else begin
          pf_vld_d = 1'b0;
        end
        if (pf_vld_q) begin
          cur_we_o    = 1'b1;
          cur_addr_o  = pf_wa_q;
          cur_wdata_o = run_q;
          run_d       = run_q + bin_rdata_i;
        end
        if (pf_addr_q[VALUE_BITS] && pf_vld_q) begin
          sc_i_d = '0;
          if (count_q == '0) begin
            sorted_d = 1'b1;
            rdpos_d  = '0;
          end
        end
      end
      ST_SC_PIX: begin
        pix_addr_o = sc_i_q[IDX_W-1:0];
      end
      ST_SC_CUR: begin
        cur_addr_o = pix_rdata_i;
        sc_val_d   = pix_rdata_i;
      end
      ST_SC_WR: begin
        ord_we_o    = 1'b1;
        ord_addr_o  = cur_rdata_i[IDX_W-1:0];
        ord_wdata_o = sc_i_q[IDX_W-1:0];
        cur_we_o    = 1'b1;
        cur_addr_o  = sc_val_q;
        cur_wdata_o = cur_rdata_i + CNT_W'(1);
        sc_i_d      = sc_next;
        if (sc_next == count_q) begin
          sorted_d = 1'b1;
          rdpos_d  = '0;
        end
      end
      ST_FETCH_RD: begin
        if (rdpos_q >= count_q) begin
          res_d.status = STAT_EMPTY;
        end else begin
          ord_addr_o = rdpos_q[IDX_W-1:0];
        end
      end
      ST_FETCH_WR: begin
        res_d.pixel_index = PIX_INDEX_W'(ord_rdata_i);
        res_d.last_index  = (rd_next == count_q);
        res_d.status      = STAT_OK;
        rdpos_d           = rd_next;
      end
      ST_RESP: begin
        res_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      clr_load_q <= 1'b0;
      count_q    <= '0;
      rdpos_q    <= '0;
      sorted_q   <= 1'b0;
      pf_addr_q  <= '0;
      pf_vld_q   <= 1'b0;
      sc_i_q     <= '0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      clr_load_q <= clr_load_d;
      count_q    <= count_d;
      rdpos_q    <= rdpos_d;
      sorted_q   <= sorted_d;
      pf_addr_q  <= pf_addr_d;
      pf_vld_q   <= pf_vld_d;
      sc_i_q     <= sc_i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    pf_wa_q  <= pf_wa_d;
    run_q    <= run_d;
    sc_val_q <= sc_val_d;
    res_q    <= res_d;
  end

  a_rdpos_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdpos_q <= count_q)
    else $error("read position beyond loaded image");

  a_count_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_PIXELS))
    else $error("pixel count beyond store depth");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept_i |=> state_q != ST_IDLE)
    else $error("accepted word did not start work");

  a_scatter_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SC_WR |-> cur_rdata_i < count_q)
    else $error("scatter position outside image");

endmodule

`default_nettype wire

// ===== hw/rtl/sort_pixel_indices_by_value_top.sv =====
// Top level of the stable counting-sort pixel index sorter.
//
// Input stream: each word either loads one grayscale pixel (tuser[0] low) or
// fetches the next pixel index in ascending value order (tuser[0] high).
// tuser[1] on a load starts a new image. Every word yields exactly one
// output word: index in tdata, last index of the run in tlast, status in
// tuser (ok, load dropped because the store is full, nothing left to fetch).
// A load reads its histogram bin and writes it back incremented before its
// result is passed on; a load into a full store goes straight to the full
// status. A load that starts a new image first clears all 2^VALUE_BITS bins.
// A fetch reads the next index from the order RAM or reports empty; the
// first fetch after loading first runs the sort: a prefix sum over the bins,
// then per loaded pixel a dependent pixel read, cursor read and cursor write.
// One word is in work at a time: the next input word is taken the cycle
// after the result enters the output register. After reset all 2^VALUE_BITS
// bins are cleared while tready stays low. A finished word waits in the
// output register when the receiver stalls; the next input word is still
// taken meanwhile and waits for the register to drain.
`default_nettype none

module sort_pixel_indices_by_value_top
  import spiv_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // pixel_value[7:0]
  input  wire logic [1:0]  s_axis_tuser_i,  // opcode[0], first_pixel[1]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // pixel_index[13:0], zero[15:14]
  output logic             m_axis_tlast_o,
  output logic [1:0]       m_axis_tuser_o   // status[1:0]
);

  localparam int unsigned NUM_BINS = 1 << VALUE_BITS;
  localparam int unsigned IDX_W    = $clog2(MAX_PIXELS);
  localparam int unsigned CNT_W    = $clog2(MAX_PIXELS + 1);

  logic                  in_accept;
  logic                  res_valid;
  logic                  res_take;
  res_t                  res;
  logic                  out_valid_q, out_valid_d;
  res_t                  out_res_q;
  logic                  bin_we, cur_we, pix_we, ord_we;
  logic [VALUE_BITS-1:0] bin_addr, cur_addr;
  logic [CNT_W-1:0]      bin_wdata, bin_rdata, cur_wdata, cur_rdata;
  logic [IDX_W-1:0]      pix_addr, ord_addr, ord_wdata, ord_rdata;
  logic [VALUE_BITS-1:0] pix_wdata, pix_rdata;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign res_take  = res_valid && (!out_valid_q || m_axis_tready_i);

  spiv_ctrl #(
    .MAX_PIXELS (MAX_PIXELS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .opcode_i    (opcode_e'(s_axis_tuser_i[0])),
    .value_i     (VALUE_BITS'(s_axis_tdata_i)),
    .first_i     (s_axis_tuser_i[1]),
    .ready_o     (s_axis_tready_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take),
    .bin_we_o    (bin_we),
    .bin_addr_o  (bin_addr),
    .bin_wdata_o (bin_wdata),
    .bin_rdata_i (bin_rdata),
    .cur_we_o    (cur_we),
    .cur_addr_o  (cur_addr),
    .cur_wdata_o (cur_wdata),
    .cur_rdata_i (cur_rdata),
    .pix_we_o    (pix_we),
    .pix_addr_o  (pix_addr),
    .pix_wdata_o (pix_wdata),
    .pix_rdata_i (pix_rdata),
    .ord_we_o    (ord_we),
    .ord_addr_o  (ord_addr),
    .ord_wdata_o (ord_wdata),
    .ord_rdata_i (ord_rdata)
  );

  spiv_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BINS)) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .addr_i  (bin_addr),
    .wdata_i (bin_wdata),
    .rdata_o (bin_rdata)
  );

  spiv_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BINS)) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .addr_i  (cur_addr),
    .wdata_i (cur_wdata),
    .rdata_o (cur_rdata)
  );

  spiv_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_PIXELS)) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .addr_i  (pix_addr),
    .wdata_i (pix_wdata),
    .rdata_o (pix_rdata)
  );

  spiv_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PIXELS)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .addr_i  (ord_addr),
    .wdata_i (ord_wdata),
    .rdata_o (ord_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    if (res_take)        out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_res_q.pixel_index};
  assign m_axis_tlast_o  = out_res_q.last_index;
  assign m_axis_tuser_o  = out_res_q.status;

endmodule

`default_nettype wire

// ===== verif/sort_pixel_indices_by_value_top_tb.sv =====
// Self-checking testbench for the pixel index sorter: directed and random load/fetch streams.
module sort_pixel_indices_by_value_top_tb;
  import spiv_pkg::*;

  localparam int unsigned NUM_BINS = 1 << VALUE_BITS_DEF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b1;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic [1:0]  m_axis_tuser_o;

  sort_pixel_indices_by_value_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // image and sort state of the predictor
  int unsigned hist_count [NUM_BINS];
  int unsigned bin_cursor [NUM_BINS];
  logic [7:0]  image_pixels [MAX_PIXELS_DEF];
  logic [13:0] sorted_order [MAX_PIXELS_DEF];
  int unsigned image_size = 0;
  int unsigned next_rank = 0;
  bit          order_valid = 1'b0;

  res_t        expected_words [$];
  res_t        oldest_word;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  bit          idling_on = 1'b1;
  int unsigned stall_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #40000000;
    $display("** sort_pixel_indices_by_value_top: FAILED **");
    $finish;
  end

  function automatic res_t predict_word(opcode_e op, logic [7:0] value, logic first);
    res_t        r;
    int unsigned run;
    r.pixel_index = '0;
    r.last_index  = 1'b0;
    r.status      = STAT_OK;
    if (op == OP_LOAD) begin
      if (first) begin
        foreach (hist_count[v]) hist_count[v] = 0;
        image_size = 0;
      end
      order_valid = 1'b0;
      next_rank   = 0;
      if (image_size < MAX_PIXELS_DEF) begin
        image_pixels[image_size] = value;
        hist_count[value]++;
        image_size++;
      end else begin
        r.status = STAT_FULL;
      end
    end else begin
      if (!order_valid) begin
        run = 0;
        for (int v = 0; v < NUM_BINS; v++) begin
          bin_cursor[v] = run;
          run += hist_count[v];
        end
        for (int i = 0; i < image_size; i++) begin
          sorted_order[bin_cursor[image_pixels[i]]] = i[13:0];
          bin_cursor[image_pixels[i]]++;
        end
        order_valid = 1'b1;
        next_rank   = 0;
      end
      if (next_rank >= image_size) begin
        r.status = STAT_EMPTY;
      end else begin
        r.pixel_index = sorted_order[next_rank];
        r.last_index  = (next_rank + 1 == image_size);
        next_rank++;
      end
    end
    return r;
  endfunction

  // hold the word until taken, then queue its result
  task automatic send_word(opcode_e op, logic [7:0] value, logic first);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= {first, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_words.push_back(predict_word(op, value, first));
    words_sent++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!idling_on) begin
      stall_left      <= 0;
      m_axis_tready_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= (stall_left == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left      <= $urandom_range(1, 8);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: tdata %0h last %0b status %0d",
                   m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
      end else begin
        oldest_word = expected_words.pop_front();
        if (m_axis_tdata_o !== {2'b00, oldest_word.pixel_index} ||
            m_axis_tlast_o !== oldest_word.last_index ||
            m_axis_tuser_o !== oldest_word.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected index %0d last %0b status %0d, got tdata %0d last %0b status %0d",
                     oldest_word.pixel_index, oldest_word.last_index, oldest_word.status,
                     m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
        end
      end
    end
  end

  task automatic test_empty_image();
    send_word(OP_FETCH, 8'h00, 1'b0);
    send_word(OP_FETCH, 8'hFF, 1'b1);
    wait_for_results();
  endtask

  task automatic test_value_extremes();
    send_word(OP_LOAD, 8'hFF, 1'b1);
    send_word(OP_LOAD, 8'h00, 1'b0);
    send_word(OP_LOAD, 8'hFF, 1'b0);
    send_word(OP_LOAD, 8'h80, 1'b0);
    send_word(OP_LOAD, 8'h7F, 1'b0);
    send_word(OP_LOAD, 8'h00, 1'b0);
    repeat (7) send_word(OP_FETCH, 8'h55, 1'b1);
    wait_for_results();
  endtask

  task automatic test_reload_after_fetch();
    send_word(OP_LOAD, 8'h10, 1'b1);
    send_word(OP_LOAD, 8'h05, 1'b0);
    send_word(OP_FETCH, 8'hAA, 1'b0);
    send_word(OP_LOAD, 8'h05, 1'b0);
    repeat (4) send_word(OP_FETCH, 8'h00, 1'b0);
    wait_for_results();
  endtask

  task automatic test_store_full();
    for (int k = 0; k < MAX_PIXELS_DEF; k++)
      send_word(OP_LOAD, 8'($urandom), k == 0);
    send_word(OP_LOAD, 8'hFF, 1'b0);
    send_word(OP_LOAD, 8'h00, 1'b0);
    for (int k = 0; k <= MAX_PIXELS_DEF; k++)
      send_word(OP_FETCH, 8'($urandom), 1'($urandom));
    send_word(OP_LOAD, 8'h3C, 1'b0);
    repeat (2) send_word(OP_FETCH, 8'h00, 1'b0);
    wait_for_results();
  endtask

  task automatic test_random_images(int unsigned count);
    int unsigned target;
    int unsigned size;
    int unsigned fetches;
    bit          narrow;
    logic [7:0]  base;
    logic [7:0]  value;
    target = words_sent + count;
    while (words_sent < target) begin
      if (target - words_sent < count / 4) idling_on = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          send_word(opcode_e'($urandom_range(0, 1)), 8'($urandom), 1'($urandom));
      end else begin
        size    = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
        narrow  = 1'($urandom);
        base    = 8'($urandom);
        for (int k = 0; k < size; k++) begin
          value = narrow ? (base | 8'($urandom & 3)) : 8'($urandom);
          send_word(OP_LOAD, value, k == 0);
        end
        fetches = size + $urandom_range(0, 2);
        for (int k = 0; k < fetches; k++) begin
          if ($urandom_range(0, 24) == 0) send_word(OP_LOAD, 8'($urandom), 1'b0);
          send_word(OP_FETCH, 8'($urandom), 1'($urandom));
        end
      end
    end
    wait_for_results();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_image();
    test_value_extremes();
    test_reload_after_fetch();
    test_store_full();
    test_random_images(1200);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("** sort_pixel_indices_by_value_top: PASSED **");
    end else begin
      $display("** sort_pixel_indices_by_value_top: FAILED **");
    end
    $finish;
  end

endmodule
